### hdl/babtb_pkg.sv
// Shared types and constants for the block-ahead branch target buffer.
// No dependencies.
package babtb_pkg;

    localparam int ADDR_W              = 48;
    localparam int DEF_TABLE_SETS      = 2048;
    localparam int DEF_TABLE_WAYS      = 4;
    localparam int DEF_INDIRECT_ENTRIES = 4096;
    localparam int DEF_STACK_DEPTH     = 64;
    localparam int DEF_LENGTH_ENTRIES  = 1024;
    localparam int LEN_LIMIT           = 10;
    localparam logic [3:0] LEN_RESET   = 4'd4;

    // resolved branch types
    localparam logic [2:0] BT_NONE     = 3'd0;
    localparam logic [2:0] BT_JUMP     = 3'd1;
    localparam logic [2:0] BT_INDIRECT = 3'd2;
    localparam logic [2:0] BT_COND     = 3'd3;
    localparam logic [2:0] BT_CALL     = 3'd4;
    localparam logic [2:0] BT_IND_CALL = 3'd5;
    localparam logic [2:0] BT_RETURN   = 3'd6;
    localparam logic [2:0] BT_OTHER    = 3'd7;

    // transitions out of the previous branch
    localparam logic [1:0] TR_TAKEN = 2'd0;
    localparam logic [1:0] TR_NOT   = 2'd1;
    localparam logic [1:0] TR_CALL  = 2'd2;

    localparam logic ACT_PREDICT = 1'b0;
    localparam logic ACT_UPDATE  = 1'b1;

    typedef enum logic [1:0] {
        KIND_INDIRECT = 2'd0,
        KIND_RETURN   = 2'd1,
        KIND_ALWAYS   = 2'd2,
        KIND_COND     = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_READ2,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] branch_ip;
        logic [ADDR_W-1:0] resolved_target;
        logic              taken;
        logic [2:0]        br_class;
    } in_t;

    typedef struct packed {
        logic [ADDR_W-1:0] pred_addr;
        logic              uncond;
    } out_t;

endpackage

### hdl/block_ahead_branch_target_buffer.sv
// One request is in flight: read, call-length read (addressed by the stack read)
// and execute, then a return to idle to take the next request; a new request is
// not accepted until the previous one is through.
// A stalled result holds the execute step until m_ready.
// Reset (aresetn, synchronous, active low) starts a clearing pass over the set,
// indirect and length tables, during which s_ready stays low. Set, indirect and
// length counts must be powers of two; the block itself does not enforce it.
module block_ahead_branch_target_buffer
    import babtb_pkg::*;
#(
    parameter int TABLE_SETS       = DEF_TABLE_SETS,
    parameter int TABLE_WAYS       = DEF_TABLE_WAYS,
    parameter int INDIRECT_ENTRIES = DEF_INDIRECT_ENTRIES,
    parameter int STACK_DEPTH      = DEF_STACK_DEPTH,
    parameter int LENGTH_ENTRIES   = DEF_LENGTH_ENTRIES
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int SET_W  = $clog2(TABLE_SETS);
    localparam int IND_W  = $clog2(INDIRECT_ENTRIES);
    localparam int LEN_W  = $clog2(LENGTH_ENTRIES);
    localparam int STK_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int AGE_W  = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
    localparam int WAY_W  = AGE_W;
    localparam int OLD_W  = AGE_W + 1;
    localparam int TAG_W  = ADDR_W - 2;
    localparam int ENT_W  = 1 + TAG_W + ADDR_W + 2 + AGE_W;
    localparam int ROW_W  = TABLE_WAYS * ENT_W;
    localparam int CLR_A  = (TABLE_SETS > INDIRECT_ENTRIES) ? TABLE_SETS : INDIRECT_ENTRIES;
    localparam int CLR_MAX = (CLR_A > LENGTH_ENTRIES) ? CLR_A : LENGTH_ENTRIES;
    localparam int CLR_W  = $clog2(CLR_MAX + 1);

    // memories
    logic [ROW_W-1:0]  tbl_mem [TABLE_SETS];
    logic [ADDR_W-1:0] ind_mem [INDIRECT_ENTRIES];
    logic [3:0]        len_mem [LENGTH_ENTRIES];
    logic [ADDR_W-1:0] stk_mem [STACK_DEPTH];

    logic [ROW_W-1:0]  row_q;
    logic [ADDR_W-1:0] ind_q;
    logic [3:0]        len_q;
    logic [ADDR_W-1:0] stk_q;

    state_t            state_reg, state_next;
    in_t               req_reg;
    logic [CLR_W-1:0]  clr_reg;
    logic [ADDR_W-1:0] prev_reg;
    logic [1:0]        trans_reg;
    logic [IND_W-1:0]  hist_reg;
    logic [STK_W-1:0]  top_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              m_valid_reg;
    out_t              m_data_reg;

    // write controls
    logic              tbl_we, ind_we, len_we, stk_we;
    logic [SET_W-1:0]  tbl_waddr;
    logic [ROW_W-1:0]  tbl_wdata;
    logic [IND_W-1:0]  ind_waddr;
    logic [ADDR_W-1:0] ind_wdata;
    logic [LEN_W-1:0]  len_waddr;
    logic [3:0]        len_wdata;
    logic              exec_go, clearing, out_load;

    // lookup key
    logic [SET_W-1:0]  key_set;
    logic [TAG_W-1:0]  key_tag;
    logic [IND_W-1:0]  ind_idx;
    logic [IND_W-1:0]  p_low;

    always_comb begin
        key_set = prev_reg[2 +: SET_W];
        key_tag = prev_reg[ADDR_W-1:2] ^ {{(TAG_W-2){1'b0}}, trans_reg};
        p_low   = prev_reg[2 +: IND_W];
        ind_idx = p_low ^ (p_low << (IND_W / 2)) ^ {trans_reg, {(IND_W-2){1'b0}}} ^ hist_reg;
    end

    // unpack the set
    logic [TABLE_WAYS-1:0] e_valid;
    logic [TAG_W-1:0]      e_tag    [TABLE_WAYS];
    logic [ADDR_W-1:0]     e_target [TABLE_WAYS];
    logic [1:0]            e_kind   [TABLE_WAYS];
    logic [AGE_W-1:0]      e_age    [TABLE_WAYS];

    always_comb begin
        for (int w = 0; w < TABLE_WAYS; w++) begin
            e_valid[w]  = row_q[w*ENT_W + ENT_W - 1];
            e_tag[w]    = row_q[w*ENT_W + AGE_W + 2 + ADDR_W +: TAG_W];
            e_target[w] = row_q[w*ENT_W + AGE_W + 2 +: ADDR_W];
            e_kind[w]   = row_q[w*ENT_W + AGE_W +: 2];
            e_age[w]    = row_q[w*ENT_W +: AGE_W];
        end
    end

    // hit search and victim choice
    logic             hit;
    logic [WAY_W-1:0] hit_way, vic_way, tw;
    logic             found_inv;
    logic [AGE_W-1:0] best_age;

    always_comb begin
        hit       = 1'b0;
        hit_way   = '0;
        vic_way   = '0;
        found_inv = 1'b0;
        best_age  = '0;
        for (int w = 0; w < TABLE_WAYS; w++) begin
            if (!hit && e_valid[w] && e_tag[w] == key_tag) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!found_inv) begin
                if (!e_valid[w]) begin
                    found_inv = 1'b1;
                    vic_way   = WAY_W'(w);
                end else if (e_age[w] >= best_age) begin
                    best_age = e_age[w];
                    vic_way  = WAY_W'(w);
                end
            end
        end
        tw = hit ? hit_way : vic_way;
    end

    // update decode
    logic              is_upd, is_call, is_ret, is_ind, is_cond, refill, do_touch, pop_ok;
    logic [1:0]        new_trans;
    kind_t             new_kind;
    logic [ADDR_W-1:0] span;
    logic [STK_W-1:0]  top_inc, top_dec;

    always_comb begin
        is_upd  = (req_reg.action == ACT_UPDATE);
        is_call = (req_reg.br_class == BT_CALL) || (req_reg.br_class == BT_IND_CALL);
        is_ret  = (req_reg.br_class == BT_RETURN);
        is_ind  = (req_reg.br_class == BT_INDIRECT) || (req_reg.br_class == BT_IND_CALL);
        is_cond = (req_reg.br_class == BT_COND) || (req_reg.br_class == BT_OTHER);
        refill  = is_upd && (req_reg.resolved_target != '0);
        do_touch = hit || refill;
        pop_ok  = is_ret && (count_reg != '0);
        if (is_call) begin
            new_trans = TR_CALL;
        end else if (req_reg.taken && !is_ret) begin
            new_trans = TR_TAKEN;
        end else begin
            new_trans = TR_NOT;
        end
        if (is_ind) begin
            new_kind = KIND_INDIRECT;
        end else if (is_ret) begin
            new_kind = KIND_RETURN;
        end else if (is_cond) begin
            new_kind = KIND_COND;
        end else begin
            new_kind = KIND_ALWAYS;
        end
        span = (stk_q >= req_reg.resolved_target) ? stk_q - req_reg.resolved_target
                                                  : req_reg.resolved_target - stk_q;
        top_inc = (top_reg == STK_W'(STACK_DEPTH - 1)) ? '0 : top_reg + 1'b1;
        top_dec = (top_reg == '0) ? STK_W'(STACK_DEPTH - 1) : top_reg - 1'b1;
    end

    // touch and refill the set
    logic [ROW_W-1:0] row_new;
    logic [OLD_W-1:0] old_age;

    always_comb begin
        row_new = row_q;
        old_age = e_valid[tw] ? {1'b0, e_age[tw]} : OLD_W'(TABLE_WAYS);
        for (int w = 0; w < TABLE_WAYS; w++) begin
            if (WAY_W'(w) != tw && e_valid[w] && {1'b0, e_age[w]} < old_age) begin
                row_new[w*ENT_W +: AGE_W] = e_age[w] + 1'b1;
            end
        end
        row_new[tw*ENT_W +: AGE_W] = '0;
        if (refill) begin
            row_new[tw*ENT_W + AGE_W +: ENT_W - AGE_W] =
                {1'b1, key_tag, req_reg.resolved_target, new_kind};
        end
    end

    // prediction
    out_t pred;

    always_comb begin
        pred.pred_addr = '0;
        pred.uncond    = 1'b0;
        if (hit) begin
            pred.uncond = 1'b1;
            unique case (kind_t'(e_kind[hit_way]))
                KIND_RETURN: begin
                    if (count_reg != '0) begin
                        pred.pred_addr = stk_q + {{(ADDR_W-4){1'b0}}, len_q};
                    end
                end
                KIND_INDIRECT: pred.pred_addr = ind_q;
                KIND_COND: begin
                    pred.pred_addr = e_target[hit_way];
                    pred.uncond    = 1'b0;
                end
                default: pred.pred_addr = e_target[hit_way];
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == CLR_W'(CLR_MAX - 1)) state_next = ST_IDLE;
            end
            ST_IDLE:  if (s_valid) state_next = ST_READ;
            ST_READ:  state_next = ST_READ2;
            ST_READ2: state_next = ST_EXEC;
            ST_EXEC:  if (exec_go) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs and write enables
    always_comb begin
        s_ready  = (state_reg == ST_IDLE);
        clearing = (state_reg == ST_CLEAR);
        exec_go  = (state_reg == ST_EXEC) && (is_upd || !m_valid_reg || m_ready);
        out_load = exec_go && !is_upd;

        tbl_we    = (clearing && clr_reg < CLR_W'(TABLE_SETS)) || (exec_go && do_touch);
        tbl_waddr = clearing ? clr_reg[SET_W-1:0] : key_set;
        tbl_wdata = clearing ? '0 : row_new;

        ind_we    = (clearing && clr_reg < CLR_W'(INDIRECT_ENTRIES)) || (exec_go && is_upd && is_ind);
        ind_waddr = clearing ? clr_reg[IND_W-1:0] : ind_idx;
        ind_wdata = clearing ? '0 : req_reg.resolved_target;

        len_we    = (clearing && clr_reg < CLR_W'(LENGTH_ENTRIES))
                 || (exec_go && is_upd && pop_ok && span <= ADDR_W'(LEN_LIMIT));
        len_waddr = clearing ? clr_reg[LEN_W-1:0] : stk_q[LEN_W-1:0];
        len_wdata = clearing ? LEN_RESET : span[3:0];

        stk_we    = exec_go && is_upd && is_call;
    end

    // memory ports
    always_ff @(posedge aclk) begin
        row_q <= tbl_mem[key_set];
        if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    end

    always_ff @(posedge aclk) begin
        ind_q <= ind_mem[ind_idx];
        if (ind_we) ind_mem[ind_waddr] <= ind_wdata;
    end

    always_ff @(posedge aclk) begin
        len_q <= len_mem[stk_q[LEN_W-1:0]];
        if (len_we) len_mem[len_waddr] <= len_wdata;
    end

    always_ff @(posedge aclk) begin
        stk_q <= stk_mem[top_reg];
        if (stk_we) stk_mem[top_inc] <= req_reg.branch_ip;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            prev_reg    <= '0;
            trans_reg   <= TR_NOT;
            hist_reg    <= '0;
            top_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (clearing) clr_reg <= clr_reg + 1'b1;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (exec_go && is_upd) begin
                prev_reg  <= req_reg.branch_ip;
                trans_reg <= new_trans;
                if (is_cond) hist_reg <= {hist_reg[IND_W-2:0], req_reg.taken};
                if (is_call) begin
                    top_reg <= top_inc;
                    if (count_reg < CNT_W'(STACK_DEPTH)) count_reg <= count_reg + 1'b1;
                end else if (pop_ok) begin
                    top_reg   <= top_dec;
                    count_reg <= count_reg - 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) req_reg <= s_data;
        if (out_load) m_data_reg <= pred;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### hdl/babtb_checker.sv
// Port-level checks for the branch target buffer, bound to the top level.
// Depends on babtb_pkg.
module babtb_checker
    import babtb_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input in_t  s_data,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("activity right after reset");

    // one request in flight
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request accepted back to back");

    // an update never yields a result
    a_update_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.action == ACT_UPDATE && !m_valid |=> ##3 !m_valid)
        else $error("result after update");

endmodule

bind block_ahead_branch_target_buffer babtb_checker u_babtb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

### sim/testbench.sv
// Self-checking testbench for the block-ahead branch target buffer.
// Depends on babtb_pkg and block_ahead_branch_target_buffer; a built-in predictor
// computes the expected predictions, which are checked in order of arrival.
module testbench;
    import babtb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETS     = DEF_TABLE_SETS;
    localparam int WAYS     = DEF_TABLE_WAYS;
    localparam int IND_N    = DEF_INDIRECT_ENTRIES;
    localparam int HIST_W   = 12;
    localparam int RAS_N    = DEF_STACK_DEPTH;
    localparam int LEN_N    = DEF_LENGTH_ENTRIES;
    localparam longint CYCLE_LIMIT = 400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    always #1 aclk = ~aclk;

    block_ahead_branch_target_buffer DUT (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // predictor state
    logic [45:0]       btb_tag [SETS*WAYS];
    bit                btb_vld [SETS*WAYS];
    logic [47:0]       btb_tgt [SETS*WAYS];
    kind_t             btb_kind[SETS*WAYS];
    int unsigned       btb_age [SETS*WAYS];
    logic [47:0]       ind_tgt [IND_N];
    logic [HIST_W-1:0] dir_hist;
    logic [47:0]       ras     [RAS_N];
    int unsigned       ras_top, ras_cnt;
    logic [3:0]        call_len[LEN_N];
    logic [47:0]       prev_ip;
    logic [1:0]        prev_tr;

    in_t  pending_reqs[$];
    out_t expected_preds[$];
    int   errors = 0;
    int   preds_checked = 0;
    int   updates_sent = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_recv = 0;
    bit   in_acc = 1'b0;
    longint cycles = 0;
    event hold_go;

    function automatic void predictor_reset();
        for (int i = 0; i < SETS*WAYS; i++) begin
            btb_vld[i] = 0;
            btb_age[i] = 0;
            btb_tag[i] = '0;
            btb_tgt[i] = '0;
            btb_kind[i] = KIND_ALWAYS;
        end
        for (int i = 0; i < IND_N; i++) ind_tgt[i] = '0;
        for (int i = 0; i < LEN_N; i++) call_len[i] = LEN_RESET;
        for (int i = 0; i < RAS_N; i++) ras[i] = '0;
        dir_hist = '0;
        ras_top = 0;
        ras_cnt = 0;
        prev_ip = '0;
        prev_tr = TR_NOT;
    endfunction

    function automatic void add_req(in_t q);
        pending_reqs.insert(pending_reqs.size(), q);
    endfunction

    function automatic int find_way(int base, logic [45:0] tag);
        for (int w = 0; w < WAYS; w++)
            if (btb_vld[base+w] && btb_tag[base+w] == tag) return w;
        return -1;
    endfunction

    function automatic void make_mru(int base, int way);
        int unsigned prior;
        prior = btb_vld[base+way] ? btb_age[base+way] : WAYS;
        for (int w = 0; w < WAYS; w++)
            if (w != way && btb_vld[base+w] && btb_age[base+w] < prior)
                btb_age[base+w]++;
        btb_age[base+way] = 0;
    endfunction

    function automatic int unsigned ind_slot();
        logic [45:0] p;
        logic [63:0] h;
        p = prev_ip[47:2];
        h = {18'd0, p} ^ ({18'd0, p} << (HIST_W/2)) ^ (64'(prev_tr) << (HIST_W-2))
            ^ 64'(dir_hist);
        return 32'(h % IND_N);
    endfunction

    function automatic out_t predict_target();
        out_t r;
        int base, way, i;
        logic [47:0] call;
        r = '0;
        base = int'(prev_ip[47:2] % SETS) * WAYS;
        way = find_way(base, prev_ip[47:2] ^ 46'(prev_tr));
        if (way >= 0) begin
            i = base + way;
            make_mru(base, way);
            r.pred_addr = btb_tgt[i];
            r.uncond = 1'b1;
            case (btb_kind[i])
                KIND_RETURN: begin
                    if (ras_cnt == 0) r.pred_addr = '0;
                    else begin
                        call = ras[ras_top];
                        r.pred_addr = call + 48'(call_len[call % LEN_N]);
                    end
                end
                KIND_INDIRECT: r.pred_addr = ind_tgt[ind_slot()];
                KIND_COND: r.uncond = 1'b0;
                default: ;
            endcase
        end
        return r;
    endfunction

    function automatic void apply_update(in_t q);
        bit is_call;
        logic [1:0] tr;
        logic [47:0] call, span;
        kind_t k;
        int base, way;
        logic [45:0] tag;
        is_call = q.br_class == BT_CALL || q.br_class == BT_IND_CALL;
        tr = is_call ? TR_CALL : ((q.taken && q.br_class != BT_RETURN) ? TR_TAKEN : TR_NOT);
        if (is_call) begin
            ras_top = (ras_top + 1) % RAS_N;
            ras[ras_top] = q.branch_ip;
            if (ras_cnt < RAS_N) ras_cnt++;
        end
        if (q.br_class == BT_RETURN && ras_cnt > 0) begin
            call = ras[ras_top];
            ras_top = (ras_top + RAS_N - 1) % RAS_N;
            ras_cnt--;
            span = call >= q.resolved_target ? call - q.resolved_target
                                             : q.resolved_target - call;
            if (span <= LEN_LIMIT) call_len[call % LEN_N] = span[3:0];
        end
        if (q.br_class == BT_INDIRECT || q.br_class == BT_IND_CALL)
            ind_tgt[ind_slot()] = q.resolved_target;
        if (q.br_class == BT_COND || q.br_class == BT_OTHER)
            dir_hist = {dir_hist[HIST_W-2:0], q.taken};
        k = KIND_ALWAYS;
        if (q.br_class == BT_INDIRECT || q.br_class == BT_IND_CALL) k = KIND_INDIRECT;
        else if (q.br_class == BT_RETURN) k = KIND_RETURN;
        else if (q.br_class == BT_COND || q.br_class == BT_OTHER) k = KIND_COND;
        base = int'(prev_ip[47:2] % SETS) * WAYS;
        tag = prev_ip[47:2] ^ 46'(prev_tr);
        way = find_way(base, tag);
        if (way >= 0) make_mru(base, way);
        if (q.resolved_target != '0) begin
            if (way < 0) begin
                int unsigned oldest;
                oldest = 0;
                way = -1;
                for (int w = 0; w < WAYS; w++)
                    if (way < 0 || btb_vld[base+way]) begin
                        if (!btb_vld[base+w]) way = w;
                        else if (btb_age[base+w] >= oldest) begin
                            oldest = btb_age[base+w];
                            way = w;
                        end
                    end
            end
            make_mru(base, way);
            btb_vld[base+way] = 1;
            btb_tag[base+way] = tag;
            btb_tgt[base+way] = q.resolved_target;
            btb_kind[base+way] = k;
        end
        prev_ip = q.branch_ip;
        prev_tr = tr;
    endfunction

    task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
        $display("mismatch %s: got %h want %h (prediction %0d)", what, got, want, preds_checked);
        errors++;
    endtask

    // accepted requests feed the predictor and leave the pending queue
    always @(posedge aclk) begin
        in_acc = aresetn && s_valid && s_ready;
        if (in_acc) begin
            if (s_data.action == ACT_PREDICT)
                expected_preds.insert(expected_preds.size(), predict_target());
            else begin
                apply_update(s_data);
                updates_sent++;
            end
            pending_reqs.delete(0);
        end
    end

    // driver: present the oldest pending request, advance on acceptance
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || in_acc) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_reqs[0];
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= hold_recv > 0 ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // long receiver hold-off, counted in cycles
    always begin
        @(hold_go);
        hold_recv = 300;
        while (hold_recv > 0) begin
            @(posedge aclk);
            hold_recv--;
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_preds.size() == 0) begin
                report_mismatch("unexpected prediction", m_data.pred_addr, '0);
            end else begin
                out_t e;
                e = expected_preds[0];
                expected_preds.delete(0);
                if (m_data.pred_addr !== e.pred_addr)
                    report_mismatch("pred_addr", m_data.pred_addr, e.pred_addr);
                if (m_data.uncond !== e.uncond)
                    report_mismatch("uncond", 48'(m_data.uncond), 48'(e.uncond));
                preds_checked++;
            end
        end
    end

    function automatic in_t mk(logic act, logic [47:0] ip, logic [47:0] tgt, logic tk,
                               logic [2:0] bt);
        in_t q;
        q.action = act;
        q.branch_ip = ip;
        q.resolved_target = tgt;
        q.taken = tk;
        q.br_class = bt;
        return q;
    endfunction

    // random request, mostly from a small address pool so the tables hit
    function automatic in_t rand_req(bit wild);
        in_t q;
        q.branch_ip = wild ? 48'({$urandom, $urandom})
                           : 48'h4000 + 48'($urandom_range(15) * 4);
        if (wild) q.resolved_target = 48'({$urandom, $urandom});
        else begin
            case ($urandom_range(3))
                0: q.resolved_target = '0;
                1: q.resolved_target = 48'h4000 + 48'($urandom_range(15) * 4);
                default: q.resolved_target = 48'h4000 + 48'($urandom_range(80));
            endcase
        end
        q.taken = 1'($urandom);
        q.br_class = 3'($urandom);
        q.action = $urandom_range(99) < 40 ? ACT_PREDICT : ACT_UPDATE;
        return q;
    endfunction

    task automatic drain();
        while (pending_reqs.size() > 0 || expected_preds.size() > 0 || s_valid) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic run_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++) add_req(rand_req($urandom_range(9) == 0));
        drain();
    endtask

    initial begin
        predictor_reset();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        // directed: extremes, every branch type, empty-stack return
        add_req(mk(ACT_PREDICT, '1, '1, 1'b1, BT_OTHER));
        add_req(mk(ACT_UPDATE, 48'h100, 48'h0, 1'b1, BT_NONE));
        add_req(mk(ACT_UPDATE, 48'h200, 48'h300, 1'b1, BT_RETURN));
        add_req(mk(ACT_UPDATE, 48'h100, 48'h0, 1'b0, BT_JUMP));
        add_req(mk(ACT_UPDATE, 48'h200, 48'h0, 1'b0, BT_JUMP));
        add_req(mk(ACT_PREDICT, '0, '0, 1'b0, BT_NONE));
        add_req(mk(ACT_UPDATE, '1, 48'h500, 1'b1, BT_CALL));
        add_req(mk(ACT_UPDATE, 48'h500, '1, 1'b1, BT_INDIRECT));
        add_req(mk(ACT_UPDATE, 48'h600, 48'h5, 1'b0, BT_RETURN));
        add_req(mk(ACT_UPDATE, '1, 48'h700, 1'b1, BT_IND_CALL));
        add_req(mk(ACT_PREDICT, '0, '0, 1'b0, BT_NONE));
        add_req(mk(ACT_UPDATE, 48'h500, 48'h800, 1'b1, BT_COND));
        add_req(mk(ACT_UPDATE, 48'h800, 48'h4, 1'b0, BT_OTHER));
        for (int i = 0; i < 8; i++)
            add_req(mk(ACT_UPDATE, 48'h1000 + 48'(i*4), 48'h2000, 1'b1, BT_CALL));
        add_req(mk(ACT_UPDATE, '1, 48'h6, 1'b1, BT_RETURN));
        add_req(mk(ACT_PREDICT, '0, '0, 1'b0, BT_NONE));
        drain();
        run_phase(100, 0, 0);
        run_phase(80, 87, 0);
        run_phase(80, 0, 87);
        // long receiver hold-off while requests keep coming
        -> hold_go;
        run_phase(60, 0, 0);
        run_phase(80, 9, 9);
        $display("Checked %0d predictions against %0d updates across idle and stall mixes.",
                 preds_checked, updates_sent);
        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule
